// ----- rtl/core/u2tc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the UTF-8 to terminal charset transcoder.
// No dependencies; imported by every module of the block.
package u2tc_pkg;

	localparam int MAX_OUT = 7;
	localparam logic [7:0] QMARK = 8'h3f;

	// Decoder verdict for one item: '?' marks first, then an optional code point.
	typedef struct packed {
		logic [2:0]  marks;
		logic        emit;
		logic [20:0] code;
	} gen_t;

	// Mapped text for one code point, bytes[0] goes out first.
	typedef struct packed {
		logic [2:0]      len;
		logic [3:0][7:0] bytes;
	} map_t;

	// Code point for each CP437 byte 0x80..0xFF.
	localparam logic [15:0] HIGH_MAP [128] = '{
		16'h00c7, 16'h00fc, 16'h00e9, 16'h00e2, 16'h00e4, 16'h00e0, 16'h00e5, 16'h00e7,
		16'h00ea, 16'h00eb, 16'h00e8, 16'h00ef, 16'h00ee, 16'h00ec, 16'h00c4, 16'h00c5,
		16'h00c9, 16'h00e6, 16'h00c6, 16'h00f4, 16'h00f6, 16'h00f2, 16'h00fb, 16'h00f9,
		16'h00ff, 16'h00d6, 16'h00dc, 16'h00a2, 16'h00a3, 16'h00a5, 16'h20a7, 16'h0192,
		16'h00e1, 16'h00ed, 16'h00f3, 16'h00fa, 16'h00f1, 16'h00d1, 16'h00aa, 16'h00ba,
		16'h00bf, 16'h2310, 16'h00ac, 16'h00bd, 16'h00bc, 16'h00a1, 16'h00ab, 16'h00bb,
		16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
		16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255d, 16'h255c, 16'h255b, 16'h2510,
		16'h2514, 16'h2534, 16'h252c, 16'h251c, 16'h2500, 16'h253c, 16'h255e, 16'h255f,
		16'h255a, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256c, 16'h2567,
		16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256b,
		16'h256a, 16'h2518, 16'h250c, 16'h2588, 16'h2584, 16'h258c, 16'h2590, 16'h2580,
		16'h03b1, 16'h00df, 16'h0393, 16'h03c0, 16'h03a3, 16'h03c3, 16'h00b5, 16'h03c4,
		16'h03a6, 16'h0398, 16'h03a9, 16'h03b4, 16'h221e, 16'h03c6, 16'h03b5, 16'h2229,
		16'h2261, 16'h00b1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00f7, 16'h2248,
		16'h00b0, 16'h2219, 16'h00b7, 16'h221a, 16'h207f, 16'h00b2, 16'h25a0, 16'h00a0
	};

endpackage

// ----- rtl/core/utf8_to_terminal_charset.sv -----
`timescale 1ns / 1ps
// UTF-8 to terminal charset transcoder, top level.
// An accepted item is held in the input register; with the result register empty it is then decoded
// and mapped combinationally into the result register, whose first byte drives m_tvalid.
// Throughput: one item per cycle while each gives one byte and m_tready is high; an item giving
// several bytes holds the input until the result register, draining one byte a cycle while m_tready is high, is free.
// Reset (arst_n low, async): pending sequence cleared, use_cp437 = 0, no bytes held.
module utf8_to_terminal_charset
	import u2tc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,    // use_cp437
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,      // [7:0] in_byte
	input  logic       s_tlast,      // end_of_text
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,      // [7:0] out_byte
	output logic       m_tlast       // run_last
);

	logic       use_cp437_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;
	logic       take, free, has_out;
	gen_t       gen;
	map_t       txt;

	// an item that yields nothing never waits on the result register
	assign has_out  = (gen.marks != 3'd0) || gen.emit;
	assign take     = valid_s1 && (free || !has_out);
	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_cp437_q <= 1'b0;
		end else if (cfg_we) begin
			use_cp437_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eot_s1  <= s_tlast;
		end
	end

	u2tc_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.in_byte     (byte_s1),
		.end_of_text (eot_s1),
		.gen         (gen)
	);

	u2tc_map u_map (
		.code      (gen.code),
		.use_cp437 (use_cp437_q),
		.txt       (txt)
	);

	u2tc_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take && has_out),
		.gen      (gen),
		.txt      (txt),
		.free     (free),
		.tvalid   (m_tvalid),
		.tready   (m_tready),
		.out_byte (m_tdata),
		.run_last (m_tlast)
	);

endmodule

// ----- rtl/core/u2tc_decode.sv -----
`timescale 1ns / 1ps
// UTF-8 sequence decoder: pending-sequence state and validation.
// Depends on u2tc_pkg.
module u2tc_decode
	import u2tc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output gen_t       gen
);

	logic [20:0] part_q, part_n, cat;
	logic [2:0]  exp_q, exp_n, rcv_q, rcv_n, rcv_inc;
	logic        cont, pend, bad, restart;

	assign cont    = (in_byte[7:6] == 2'b10);
	assign pend    = (exp_q != 3'd0);
	assign cat     = {part_q[14:0], in_byte[5:0]};
	assign rcv_inc = rcv_q + 3'd1;

	always_comb begin
		part_n    = part_q;
		exp_n     = exp_q;
		rcv_n     = rcv_q;
		gen.marks = 3'd0;
		gen.emit  = 1'b0;
		gen.code  = 21'd0;
		restart   = 1'b0;
		bad = ((exp_q == 3'd2) && (cat < 21'h80)) || ((exp_q == 3'd3) && (cat < 21'h800)) ||
			((exp_q == 3'd4) && (cat < 21'h10000)) || (cat > 21'h10ffff) ||
			((cat >= 21'hd800) && (cat <= 21'hdfff));
		if (pend && cont) begin
			part_n = cat;
			rcv_n  = rcv_inc;
			if (rcv_inc >= exp_q) begin
				exp_n  = 3'd0;
				rcv_n  = 3'd0;
				part_n = 21'd0;
				if (bad) begin
					gen.marks = exp_q;
				end else begin
					gen.emit = 1'b1;
					gen.code = cat;
				end
			end else if (end_of_text) begin
				gen.marks = rcv_inc;
				exp_n     = 3'd0;
				rcv_n     = 3'd0;
				part_n    = 21'd0;
			end
		end else begin
			// flush what was taken, then decode this byte as a fresh start
			if (pend) begin
				gen.marks = rcv_q;
			end
			exp_n   = 3'd0;
			rcv_n   = 3'd0;
			part_n  = 21'd0;
			restart = 1'b1;
		end
		if (restart) begin
			if (!in_byte[7]) begin
				gen.emit = 1'b1;
				gen.code = {13'd0, in_byte};
			end else if (in_byte[7:5] == 3'b110) begin
				exp_n  = 3'd2;
				part_n = {16'd0, in_byte[4:0]};
				rcv_n  = 3'd1;
			end else if (in_byte[7:4] == 4'b1110) begin
				exp_n  = 3'd3;
				part_n = {17'd0, in_byte[3:0]};
				rcv_n  = 3'd1;
			end else if (in_byte[7:3] == 5'b11110) begin
				exp_n  = 3'd4;
				part_n = {18'd0, in_byte[2:0]};
				rcv_n  = 3'd1;
			end else begin
				gen.marks = gen.marks + 3'd1;
			end
			// a lead byte at end of text is flushed at once
			if (end_of_text && (exp_n != 3'd0)) begin
				gen.marks = gen.marks + 3'd1;
				exp_n     = 3'd0;
				rcv_n     = 3'd0;
				part_n    = 21'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= 21'd0;
			exp_q  <= 3'd0;
			rcv_q  <= 3'd0;
		end else if (take) begin
			part_q <= part_n;
			exp_q  <= exp_n;
			rcv_q  <= rcv_n;
		end
	end

	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && end_of_text) |=> (exp_q == 3'd0 && rcv_q == 3'd0))
		else $error("sequence still pending after end of text");

	a_rcv_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(exp_q != 3'd0) |-> (rcv_q != 3'd0 && rcv_q < exp_q))
		else $error("pending byte count out of range");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(exp_q == 3'd0) |-> (rcv_q == 3'd0))
		else $error("byte count set with no sequence pending");

endmodule

// ----- rtl/core/u2tc_map.sv -----
`timescale 1ns / 1ps
// Code point to terminal text: control handling, CP437 table and ISO646 text.
// Depends on u2tc_pkg.
module u2tc_map
	import u2tc_pkg::*;
(
	input  logic [20:0] code,
	input  logic        use_cp437,
	output map_t        txt
);

	function automatic map_t mk(input logic [2:0] n, input logic [31:0] s);
		map_t r;
		r.len   = n;
		r.bytes = '0;
		for (int i = 0; i < 4; i++) begin
			if (i < int'(n)) begin
				r.bytes[i] = s[8*(int'(n) - 1 - i) +: 8];
			end
		end
		return r;
	endfunction

	logic       hit;
	logic [6:0] hidx;
	logic       invariant;
	map_t       cp_txt, iso_txt;

	always_comb begin
		hit  = 1'b0;
		hidx = 7'd0;
		for (int i = 0; i < 128; i++) begin
			if (code[20:16] == 5'd0 && code[15:0] == HIGH_MAP[i]) begin
				hit  = 1'b1;
				hidx = 7'(i);
			end
		end
	end

	assign invariant = (code >= 21'h20 && code <= 21'h22) || (code >= 21'h25 && code <= 21'h3f) ||
		(code >= 21'h41 && code <= 21'h5a) || (code == 21'h5f) ||
		(code >= 21'h61 && code <= 21'h7a);

	always_comb begin
		if (code >= 21'h20 && code <= 21'h7e) begin
			cp_txt = mk(3'd1, {24'd0, code[7:0]});
		end else if (hit) begin
			cp_txt = mk(3'd1, {24'd0, 1'b1, hidx});
		end else begin
			unique case (code) inside
				21'h2010, 21'h2011, 21'h2012, 21'h2013, 21'h2014, 21'h2212:
					cp_txt = mk(3'd1, 32'("-"));
				21'h2018, 21'h2019: cp_txt = mk(3'd1, 32'("'"));
				21'h201c, 21'h201d: cp_txt = mk(3'd1, 32'("\""));
				21'h2026: cp_txt = mk(3'd3, 32'("..."));
				21'h2190: cp_txt = mk(3'd2, 32'("<-"));
				21'h2192: cp_txt = mk(3'd2, 32'("->"));
				21'h2191: cp_txt = mk(3'd1, 32'("^"));
				21'h2193: cp_txt = mk(3'd1, 32'("v"));
				default:  cp_txt = mk(3'd1, {24'd0, QMARK});
			endcase
		end
	end

	always_comb begin
		if (invariant) begin
			iso_txt = mk(3'd1, {24'd0, code[7:0]});
		end else begin
			unique case (code) inside
				21'h23: iso_txt = mk(3'd3, 32'("No."));
				21'h24: iso_txt = mk(3'd3, 32'("USD"));
				21'h40: iso_txt = mk(3'd4, 32'("(at)"));
				21'h5b, 21'h7b: iso_txt = mk(3'd1, 32'("("));
				21'h5d, 21'h7d: iso_txt = mk(3'd1, 32'(")"));
				21'h5c: iso_txt = mk(3'd1, 32'("/"));
				21'h5e, 21'h2191: iso_txt = mk(3'd2, 32'("up"));
				21'h60, 21'h2018, 21'h2019: iso_txt = mk(3'd1, 32'("'"));
				21'h7c: iso_txt = mk(3'd1, 32'("!"));
				21'h7e, 21'h2010, 21'h2011, 21'h2012, 21'h2013, 21'h2014, 21'h2212:
					iso_txt = mk(3'd1, 32'("-"));
				21'h201c, 21'h201d: iso_txt = mk(3'd1, 32'("\""));
				21'h2026: iso_txt = mk(3'd3, 32'("..."));
				21'ha0:   iso_txt = mk(3'd1, 32'(" "));
				21'h2190: iso_txt = mk(3'd2, 32'("<-"));
				21'h2192: iso_txt = mk(3'd2, 32'("->"));
				21'h2193: iso_txt = mk(3'd4, 32'("down"));
				default:  iso_txt = mk(3'd1, {24'd0, QMARK});
			endcase
		end
	end

	always_comb begin
		if (code == 21'h0d || code == 21'h0a) begin
			txt = mk(3'd1, {24'd0, code[7:0]});
		end else if (code == 21'h09) begin
			txt = mk(3'd1, 32'(" "));
		end else if (code < 21'h20 || code == 21'h7f) begin
			txt = mk(3'd1, {24'd0, QMARK});
		end else if (use_cp437) begin
			txt = cp_txt;
		end else begin
			txt = iso_txt;
		end
	end

endmodule

// ----- rtl/core/u2tc_outq.sv -----
`timescale 1ns / 1ps
// Result register: holds the bytes of one item and shifts them out in order.
// Depends on u2tc_pkg.
module u2tc_outq
	import u2tc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  gen_t       gen,
	input  map_t       txt,
	output logic       free,
	output logic       tvalid,
	input  logic       tready,
	output logic [7:0] out_byte,
	output logic       run_last
);

	logic [7:0] buf_q [MAX_OUT];
	logic [7:0] fill  [MAX_OUT];
	logic [2:0] cnt_q, new_cnt, j;
	logic       pop;

	assign pop      = (cnt_q != 3'd0) && tready;
	assign free     = (cnt_q == 3'd0) || (cnt_q == 3'd1 && tready);
	assign tvalid   = (cnt_q != 3'd0);
	assign out_byte = buf_q[0];
	assign run_last = (cnt_q == 3'd1);
	assign new_cnt  = gen.marks + (gen.emit ? txt.len : 3'd0);

	// marks first, then the mapped text
	always_comb begin
		for (int i = 0; i < MAX_OUT; i++) begin
			j       = 3'(i) - gen.marks;
			fill[i] = QMARK;
			if (3'(i) >= gen.marks && j < txt.len) begin
				fill[i] = txt.bytes[j[1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= new_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= fill;
		end else if (pop) begin
			for (int i = 0; i < MAX_OUT - 1; i++) begin
				buf_q[i] <= buf_q[i + 1];
			end
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == 3'd0 || (cnt_q == 3'd1 && tready)))
		else $error("result register overwritten before drained");

	a_load_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (cnt_q != 3'd0))
		else $error("empty item loaded into result register");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(tvalid && !tready) |=> (cnt_q == $past(cnt_q)))
		else $error("result count moved while stalled");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for utf8_to_terminal_charset: streams UTF-8 bytes into
// the block, predicts the terminal bytes for both output modes and checks each one.
// Depends only on the utf8_to_terminal_charset RTL and its package.
module tb_top;

	localparam logic MODE_ISO646 = 1'b0;
	localparam logic MODE_CP437  = 1'b1;

	localparam logic [20:0] CP_TAB     = 21'h09;
	localparam logic [20:0] CP_LF      = 21'h0a;
	localparam logic [20:0] CP_CR      = 21'h0d;
	localparam logic [20:0] CP_DEL     = 21'h7f;
	localparam logic [20:0] CP_SURR_LO = 21'h00d800;
	localparam logic [20:0] CP_SURR_HI = 21'h00dfff;
	localparam logic [20:0] CP_MAX     = 21'h10ffff;
	localparam logic [7:0]  CH_QMARK   = "?";
	localparam string       SAFE_PUNCT = " !\"%&'()*+,-./:;<=>?_";
	localparam int          SETTLE_CYCLES = 8;
	localparam int          STEP_LIMIT = 8;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} term_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;

	utf8_to_terminal_charset u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),      // [7:0] in_byte
		.s_tlast  (s_tlast),      // end_of_text
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),      // [7:0] out_byte
		.m_tlast  (m_tlast)       // run_last
	);

	always #4 clk = ~clk;

	// Code point behind each CP437 byte 0x80..0xFF
	logic [15:0] cp437_upper_cp [0:127] = '{
		16'h00c7, 16'h00fc, 16'h00e9, 16'h00e2, 16'h00e4, 16'h00e0, 16'h00e5, 16'h00e7,
		16'h00ea, 16'h00eb, 16'h00e8, 16'h00ef, 16'h00ee, 16'h00ec, 16'h00c4, 16'h00c5,
		16'h00c9, 16'h00e6, 16'h00c6, 16'h00f4, 16'h00f6, 16'h00f2, 16'h00fb, 16'h00f9,
		16'h00ff, 16'h00d6, 16'h00dc, 16'h00a2, 16'h00a3, 16'h00a5, 16'h20a7, 16'h0192,
		16'h00e1, 16'h00ed, 16'h00f3, 16'h00fa, 16'h00f1, 16'h00d1, 16'h00aa, 16'h00ba,
		16'h00bf, 16'h2310, 16'h00ac, 16'h00bd, 16'h00bc, 16'h00a1, 16'h00ab, 16'h00bb,
		16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
		16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255d, 16'h255c, 16'h255b, 16'h2510,
		16'h2514, 16'h2534, 16'h252c, 16'h251c, 16'h2500, 16'h253c, 16'h255e, 16'h255f,
		16'h255a, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256c, 16'h2567,
		16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256b,
		16'h256a, 16'h2518, 16'h250c, 16'h2588, 16'h2584, 16'h258c, 16'h2590, 16'h2580,
		16'h03b1, 16'h00df, 16'h0393, 16'h03c0, 16'h03a3, 16'h03c3, 16'h00b5, 16'h03c4,
		16'h03a6, 16'h0398, 16'h03a9, 16'h03b4, 16'h221e, 16'h03c6, 16'h03b5, 16'h2229,
		16'h2261, 16'h00b1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00f7, 16'h2248,
		16'h00b0, 16'h2219, 16'h00b7, 16'h221a, 16'h207f, 16'h00b2, 16'h25a0, 16'h00a0
	};

	// Code points with a text substitution in one mode or the other, plus U+FFFD, which has none
	logic [20:0] substituted_cp [0:28] = '{
		21'h2010, 21'h2011, 21'h2012, 21'h2013, 21'h2014, 21'h2212, 21'h2018, 21'h2019,
		21'h201c, 21'h201d, 21'h2026, 21'h2190, 21'h2191, 21'h2192, 21'h2193, 21'h00a0,
		21'hfffd, 21'h23, 21'h24, 21'h40, 21'h5b, 21'h5d, 21'h7b, 21'h7d,
		21'h5c, 21'h5e, 21'h60, 21'h7c, 21'h7e
	};

	// Transcoder state as the testbench sees it
	logic        cp437_sel = MODE_ISO646;
	logic [20:0] seq_acc = '0;
	logic [2:0]  seq_len = '0;
	logic [2:0]  seq_got = '0;
	logic [7:0]  step_bytes [$];
	term_byte_t  pending_term_bytes [$];

	int  items_sent = 0;
	int  bytes_checked = 0;
	int  mode_writes = 0;
	int  eot_flushes = 0;
	int  fail_count = 0;
	bit  tx_gaps_on = 1'b1;
	bit  rx_stalls_on = 1'b1;
	int  stall_left = 0;

	function automatic void put_char(input logic [7:0] c);
		if (step_bytes.size() < STEP_LIMIT)
			step_bytes = {step_bytes, c};
	endfunction

	function automatic void put_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			put_char(s[i]);
	endfunction

	function automatic void put_marks(input int n);
		int i;
		for (i = 0; i < n; i++)
			put_char(CH_QMARK);
	endfunction

	function automatic bit is_invariant(input logic [20:0] v);
		int i;
		if ((v >= "0" && v <= "9") || (v >= "A" && v <= "Z") || (v >= "a" && v <= "z"))
			return 1'b1;
		for (i = 0; i < SAFE_PUNCT.len(); i++)
			if (v == {13'b0, SAFE_PUNCT[i]})
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void map_cp437(input logic [20:0] v);
		int i;
		if (v >= 21'h20 && v <= 21'h7e) begin
			put_char(v[7:0]);
			return;
		end
		for (i = 0; i < 128; i++) begin
			if (v == {5'b0, cp437_upper_cp[i]}) begin
				put_char(8'h80 | i[7:0]);
				return;
			end
		end
		case (v)
		21'h2010, 21'h2011, 21'h2012, 21'h2013, 21'h2014, 21'h2212: put_text("-");
		21'h2018, 21'h2019: put_text("'");
		21'h201c, 21'h201d: put_text("\"");
		21'h2026: put_text("...");
		21'h2190: put_text("<-");
		21'h2192: put_text("->");
		21'h2191: put_text("^");
		21'h2193: put_text("v");
		default: put_text("?");
		endcase
	endfunction

	function automatic void map_iso646(input logic [20:0] v);
		if (is_invariant(v)) begin
			put_char(v[7:0]);
			return;
		end
		case (v)
		21'h23: put_text("No.");
		21'h24: put_text("USD");
		21'h40: put_text("(at)");
		21'h5b, 21'h7b: put_text("(");
		21'h5d, 21'h7d: put_text(")");
		21'h5c: put_text("/");
		21'h5e: put_text("up");
		21'h60, 21'h2018, 21'h2019: put_text("'");
		21'h7c: put_text("!");
		21'h7e, 21'h2010, 21'h2011, 21'h2012, 21'h2013, 21'h2014, 21'h2212: put_text("-");
		21'h201c, 21'h201d: put_text("\"");
		21'h2026: put_text("...");
		21'h00a0: put_text(" ");
		21'h2190: put_text("<-");
		21'h2192: put_text("->");
		21'h2191: put_text("up");
		21'h2193: put_text("down");
		default: put_text("?");
		endcase
	endfunction

	function automatic void emit_code(input logic [20:0] v);
		if (v == CP_CR || v == CP_LF)
			put_char(v[7:0]);
		else if (v == CP_TAB)
			put_char(" ");
		else if (v < 21'h20 || v == CP_DEL)
			put_char(CH_QMARK);
		else if (cp437_sel == MODE_CP437)
			map_cp437(v);
		else
			map_iso646(v);
	endfunction

	function automatic void drop_sequence();
		seq_acc = '0;
		seq_len = '0;
		seq_got = '0;
	endfunction

	function automatic void start_lead(input logic [7:0] b);
		if (b < 8'h80) begin
			emit_code({13'b0, b});
		end else if (b[7:5] == 3'b110) begin
			seq_len = 3'd2; seq_acc = {16'b0, b[4:0]}; seq_got = 3'd1;
		end else if (b[7:4] == 4'b1110) begin
			seq_len = 3'd3; seq_acc = {17'b0, b[3:0]}; seq_got = 3'd1;
		end else if (b[7:3] == 5'b11110) begin
			seq_len = 3'd4; seq_acc = {18'b0, b[2:0]}; seq_got = 3'd1;
		end else begin
			put_char(CH_QMARK);
		end
	endfunction

	function automatic void close_sequence();
		logic [20:0] v;
		int          n;
		bit          bad;
		v = seq_acc;
		n = int'(seq_len);
		bad = (n == 2 && v < 21'h80) || (n == 3 && v < 21'h800) ||
		      (n == 4 && v < 21'h10000) || v > CP_MAX ||
		      (v >= CP_SURR_LO && v <= CP_SURR_HI);
		drop_sequence();
		if (bad)
			put_marks(n);
		else
			emit_code(v);
	endfunction

	// Advance the decoder by one input item and queue the terminal bytes it yields
	function automatic void transcode_byte(input logic [7:0] b, input logic eot);
		term_byte_t tb;
		int         i;
		step_bytes.delete();
		if (seq_len != 0) begin
			if (b[7:6] == 2'b10) begin
				seq_acc = {seq_acc[14:0], b[5:0]};
				seq_got = seq_got + 3'd1;
				if (seq_got >= seq_len)
					close_sequence();
			end else begin
				// broken sequence: mark what was taken, then treat this byte as a new start
				put_marks(int'(seq_got));
				drop_sequence();
				start_lead(b);
			end
		end else begin
			start_lead(b);
		end
		if (eot && seq_len != 0) begin
			put_marks(int'(seq_got));
			drop_sequence();
			eot_flushes++;
		end
		for (i = 0; i < step_bytes.size(); i++) begin
			tb.data = step_bytes[i];
			tb.last = (i == step_bytes.size() - 1);
			pending_term_bytes = {pending_term_bytes, tb};
		end
	endfunction

	// Output side: random stall bursts, then check each accepted byte in order
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 12) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		term_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			bytes_checked++;
			if (pending_term_bytes.size() == 0) begin
				$error("unexpected byte: out_byte %h run_last %b", m_tdata, m_tlast);
				fail_count++;
			end else begin
				want = pending_term_bytes.pop_front();
				if (m_tdata !== want.data) begin
					$error("out_byte: expected %h, got %h", want.data, m_tdata);
					fail_count++;
				end
				if (m_tlast !== want.last) begin
					$error("run_last: expected %b, got %b", want.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	task automatic send_item(input logic [7:0] b, input logic eot);
		if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eot;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		transcode_byte(b, eot);
		items_sent++;
	endtask

	// Hold input, wait for every queued byte, then let the pipeline settle
	task automatic wait_results(input int extra);
		s_tvalid <= 1'b0;
		while (pending_term_bytes.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_mode(input logic mode);
		wait_results(SETTLE_CYCLES);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		cp437_sel = mode;
		mode_writes++;
	endtask

	// k-th byte of the len-byte form of cp; no range checks, so bad forms come out too
	function automatic logic [7:0] utf8_unit(input logic [20:0] cp, input int len, input int k);
		if (k == 0) begin
			case (len)
			1: return cp[7:0];
			2: return {3'b110, cp[10:6]};
			3: return {4'b1110, cp[15:12]};
			default: return {5'b11110, cp[20:18]};
			endcase
		end
		return {2'b10, cp[6 * (len - 1 - k) +: 6]};
	endfunction

	task automatic send_code(input logic [20:0] cp, input int len, input int nbytes,
	                         input logic eot);
		int k;
		for (k = 0; k < nbytes; k++)
			send_item(utf8_unit(cp, len, k), eot && (k == nbytes - 1));
	endtask

	function automatic int utf8_len(input logic [20:0] cp);
		if (cp < 21'h80)
			return 1;
		if (cp < 21'h800)
			return 2;
		if (cp < 21'h10000)
			return 3;
		return 4;
	endfunction

	task automatic random_sequence();
		int          kind;
		int          len;
		logic [20:0] cp;
		logic        eot;
		kind = $urandom_range(0, 19);
		eot  = ($urandom_range(0, 15) == 0);
		if (kind <= 4) begin
			cp = 21'($urandom_range(0, 127));
			send_code(cp, 1, 1, eot);
		end else if (kind <= 7) begin
			if ($urandom_range(0, 1) == 0)
				cp = {5'b0, cp437_upper_cp[$urandom_range(0, 127)]};
			else
				cp = substituted_cp[$urandom_range(0, 28)];
			len = utf8_len(cp);
			send_code(cp, len, len, eot);
		end else if (kind <= 9) begin
			cp = 21'($urandom_range(21'h80, 21'h7ff));
			send_code(cp, 2, 2, eot);
		end else if (kind <= 11) begin
			cp = 21'($urandom_range(21'h800, 21'hffff));
			if (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
				cp[14] = 1'b0;
			send_code(cp, 3, 3, eot);
		end else if (kind == 12) begin
			cp = 21'($urandom_range(21'h10000, CP_MAX));
			send_code(cp, 4, 4, eot);
		end else if (kind <= 14) begin
			send_item(8'($urandom_range(0, 255)), eot);
		end else if (kind <= 16) begin
			// cut short: the next lead byte breaks it, or end of text flushes it
			len = $urandom_range(2, 4);
			cp  = (len == 2) ? 21'($urandom_range(21'h80, 21'h7ff)) :
			      (len == 3) ? 21'($urandom_range(21'h800, 21'hffff)) :
			                   21'($urandom_range(21'h10000, CP_MAX));
			send_code(cp, len, $urandom_range(1, len - 1), eot);
		end else if (kind == 17) begin
			len = $urandom_range(2, 4);
			cp  = (len == 2) ? 21'($urandom_range(0, 21'h7f)) :
			      (len == 3) ? 21'($urandom_range(0, 21'h7ff)) :
			                   21'($urandom_range(0, 21'hffff));
			send_code(cp, len, len, eot);
		end else if (kind == 18) begin
			cp = 21'($urandom_range(CP_SURR_LO, CP_SURR_HI));
			send_code(cp, 3, 3, eot);
		end else begin
			cp = 21'($urandom_range(21'h110000, 21'h1fffff));
			send_code(cp, 4, 4, eot);
		end
	endtask

	task automatic test_iso646_directed();
		send_item(8'h40, 1'b0);                 // at sign: four bytes
		send_item(8'h09, 1'b0);                 // tab to space
		send_item(8'h00, 1'b0);                 // control to mark
		send_item(8'h7f, 1'b0);                 // DEL to mark
		send_item(8'h80, 1'b0);                 // stray continuation as lead
		send_item(8'hff, 1'b0);                 // lead byte out of range
		send_item(8'he2, 1'b0);                 // broken three-byte start, then 'A'
		send_item(8'h41, 1'b0);
		send_code(21'h2193, 3, 3, 1'b0);        // down arrow as a word
		// three bytes taken, then '@' restarts: three marks plus "(at)"
		send_item(8'hf0, 1'b0);
		send_item(8'h9f, 1'b0);
		send_item(8'h98, 1'b0);
		send_item(8'h40, 1'b0);
		send_item(8'he2, 1'b1);                 // end of text flushes the lead
		send_code(21'h0000, 2, 2, 1'b0);        // overlong NUL
		send_code(21'hd800, 3, 3, 1'b0);        // surrogate
	endtask

	task automatic test_cp437_directed();
		write_mode(MODE_CP437);
		send_item(8'h0d, 1'b0);
		send_item(8'h0a, 1'b0);
		send_code(21'h00c7, 2, 2, 1'b0);        // first entry of the high table
		send_code(21'h110000, 4, 4, 1'b0);      // above the Unicode range
		send_code(21'h2591, 3, 3, 1'b0);        // light shade
		send_code(21'h2026, 3, 3, 1'b0);        // ellipsis to three dots
		send_code(21'hfffd, 3, 3, 1'b0);        // replacement char has no mapping
		send_item(8'hf8, 1'b1);
	endtask

	task automatic test_random_mix(input logic mode, input int n);
		int stop;
		write_mode(mode);
		stop = items_sent + n;
		while (items_sent < stop)
			random_sequence();
	endtask

	// Drain completely every so often so the block starts from empty queues
	task automatic test_drain_pause(input int n);
		int stop;
		int next_drain;
		write_mode(MODE_ISO646);
		stop = items_sent + n;
		next_drain = items_sent + 25;
		while (items_sent < stop) begin
			random_sequence();
			if (items_sent >= next_drain) begin
				wait_results(0);
				next_drain = items_sent + 25;
			end
		end
	endtask

	task automatic test_unthrottled(input int n);
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		test_random_mix(MODE_ISO646, n);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_iso646_directed();
		test_cp437_directed();
		test_random_mix(MODE_CP437, 110);
		test_drain_pause(110);
		test_random_mix(MODE_CP437, 90);
		test_unthrottled(100);
		wait_results(SETTLE_CYCLES);
		$display("run: %0d input items, %0d output bytes checked, %0d mode writes",
		         items_sent, bytes_checked, mode_writes);
		$display("run: %0d unfinished sequences flushed by end of text", eot_flushes);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("timeout: %0d output bytes still expected", pending_term_bytes.size());
		$display("status: fail");
		$finish;
	end

endmodule
